### rtl/core/itoa_fmt_pkg.sv
// Shared constants for the integer to ASCII formatter.
package itoa_fmt_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int BITS_PER_STAGE  = 8;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    localparam logic KIND_DEC = 1'b0;
    localparam logic KIND_HEX = 1'b1;

endpackage

### rtl/core/integer_to_ascii_formatter_top.sv
// Integer to ASCII formatter: pipelined binary to decimal/hex text, one character per transfer.
//
// Input channel (in_valid/in_ready): one transfer carries kind and value. Kind 0 prints value
// as signed decimal (leading '-', a single '0' for zero); kind 1 as unsigned lower-case hex
// with no leading zeros. Output channel (out_valid/out_ready): one character per transfer,
// most significant first, last high on the final character of the number.
// The decimal conversion runs as a shift-and-add-3 pipeline, 8 bits per stage, followed by a
// digit count stage and a character serializer that drives the output register.
// The serializer works on one number at a time and takes the next only when it has sent
// the last character; the conversion pipeline takes a new item every cycle while space
// remains, and a stage holds only when every stage ahead of it is full.
// When the receiver stalls, the output register holds its character, the serializer waits,
// and the pipeline fills up and then drops in_ready. Nothing is lost or repeated.
// Reset clears all valid bits and the serializer; the block is ready right after reset.
module integer_to_ascii_formatter_top
#(
    parameter int VALUE_WIDTH = itoa_fmt_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             character,
    output logic                   last
);
    import itoa_fmt_pkg::*;

    localparam int W       = VALUE_WIDTH;
    localparam int NCONV   = (W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int DEC_DIG = (W * 30103) / 100000 + 1;
    localparam int HEX_DIG = (W + 3) / 4;
    localparam int NDIG    = (DEC_DIG > HEX_DIG) ? DEC_DIG : HEX_DIG;
    localparam int DW      = 4 * NDIG;
    localparam int IW      = (NDIG > 1) ? $clog2(NDIG) : 1;

    // conversion pipeline, stage 0 is the input register
    logic          v_reg    [0:NCONV];
    logic          kind_reg [0:NCONV];
    logic          neg_reg  [0:NCONV];
    logic [W-1:0]  word_reg [0:NCONV];
    logic [W-1:0]  bin_reg  [0:NCONV];
    logic [DW-1:0] bcd_reg  [0:NCONV];
    logic [W-1:0]  bin_next [0:NCONV];
    logic [DW-1:0] bcd_next [0:NCONV];
    logic          rdy      [0:NCONV];

    // digit count stage
    logic          cv_reg;
    logic          cneg_reg;
    logic [DW-1:0] cdig_reg;
    logic [IW-1:0] ctop_reg;
    logic [DW-1:0] cdig_next;
    logic [IW-1:0] ctop_next;
    logic          c_rdy;

    // serializer and output register
    logic          busy_reg;
    logic          sdash_reg;
    logic [DW-1:0] sdig_reg;
    logic [IW-1:0] sidx_reg;
    logic          ovalid_reg;
    logic [7:0]    ochar_reg;
    logic          olast_reg;
    logic          out_free;
    logic          emit;
    logic          emit_last;
    logic [3:0]    cur_nib;
    logic [7:0]    cur_char;
    logic          in_neg;
    logic [W-1:0]  in_mag;

    assign in_neg = (kind == KIND_DEC) && value[W-1];
    assign in_mag = in_neg ? (~value + {{(W-1){1'b0}}, 1'b1}) : value;

    always_comb
    begin
        logic [W-1:0]  b;
        logic [DW-1:0] d;
        bin_next[0] = in_mag;
        bcd_next[0] = '0;
        for (int i = 1; i <= NCONV; i++)
        begin
            b = bin_reg[i-1];
            d = bcd_reg[i-1];
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                if ((i - 1) * BITS_PER_STAGE + j < W)
                begin
                    for (int k = 0; k < NDIG; k++)
                    begin
                        if (d[4*k +: 4] >= 4'd5)
                        begin
                            d[4*k +: 4] = d[4*k +: 4] + 4'd3;
                        end
                    end
                    d = {d[DW-2:0], b[W-1]};
                    b = {b[W-2:0], 1'b0};
                end
            end
            bin_next[i] = b;
            bcd_next[i] = d;
        end
    end

    assign c_rdy = !cv_reg || !busy_reg;

    always_comb
    begin
        rdy[NCONV] = !v_reg[NCONV] || c_rdy;
        for (int i = NCONV - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NCONV; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i <= NCONV; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            kind_reg[0] <= kind;
            neg_reg[0]  <= in_neg;
            word_reg[0] <= value;
            bin_reg[0]  <= bin_next[0];
            bcd_reg[0]  <= bcd_next[0];
        end
        for (int i = 1; i <= NCONV; i++)
        begin
            if (rdy[i])
            begin
                kind_reg[i] <= kind_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                word_reg[i] <= word_reg[i-1];
                bin_reg[i]  <= bin_next[i];
                bcd_reg[i]  <= bcd_next[i];
            end
        end
    end

    // pick digit set and find the most significant nonzero digit
    always_comb
    begin
        if (kind_reg[NCONV] == KIND_HEX)
        begin
            cdig_next = DW'(word_reg[NCONV]);
        end
        else
        begin
            cdig_next = bcd_reg[NCONV];
        end
        ctop_next = '0;
        for (int k = 0; k < NDIG; k++)
        begin
            if (cdig_next[4*k +: 4] != 4'd0)
            begin
                ctop_next = IW'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= 1'b0;
        end
        else if (c_rdy)
        begin
            cv_reg <= v_reg[NCONV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_rdy)
        begin
            cneg_reg <= neg_reg[NCONV];
            cdig_reg <= cdig_next;
            ctop_reg <= ctop_next;
        end
    end

    assign out_free  = !ovalid_reg || out_ready;
    assign emit      = busy_reg && out_free;
    assign emit_last = !sdash_reg && (sidx_reg == '0);
    assign cur_nib   = sdig_reg[4*sidx_reg +: 4];

    always_comb
    begin
        if (sdash_reg)
        begin
            cur_char = CHAR_MINUS;
        end
        else if (cur_nib < 4'd10)
        begin
            cur_char = CHAR_ZERO + {4'd0, cur_nib};
        end
        else
        begin
            cur_char = CHAR_A + {4'd0, cur_nib - 4'd10};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            sdash_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (!busy_reg)
            begin
                busy_reg  <= cv_reg;
                sdash_reg <= cv_reg && cneg_reg;
            end
            else if (emit)
            begin
                sdash_reg <= 1'b0;
                if (emit_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (out_free)
            begin
                ovalid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            sdig_reg <= cdig_reg;
            sidx_reg <= ctop_reg;
        end
        else if (emit && !sdash_reg && !emit_last)
        begin
            sidx_reg <= sidx_reg - {{(IW-1){1'b0}}, 1'b1};
        end
        if (emit)
        begin
            ochar_reg <= cur_char;
            olast_reg <= emit_last;
        end
    end

    assign out_valid = ovalid_reg;
    assign character = ochar_reg;
    assign last      = olast_reg;

    a_last_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_last |=> out_valid && last)
        else $error("final digit not marked last");

    a_dash_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sdash_reg |-> busy_reg)
        else $error("sign pending while serializer idle");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (character == CHAR_MINUS) |-> !last)
        else $error("minus sign marked last");

endmodule

### sim/itoa_fmt_checker.sv
// Checker for the integer to ASCII formatter: predicts characters per input and compares.
`timescale 1ns / 100ps
module itoa_fmt_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [31:0] value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  character,
    input  logic        last,
    output int          errors,
    output int          pending
);
    import itoa_fmt_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    text_char_t expected_text[$];

    function automatic logic [7:0] digit_to_ascii(input logic [31:0] d);
        if (d < 10)
            return CHAR_ZERO + d[7:0];
        return CHAR_A + d[7:0] - 8'd10;
    endfunction

    task automatic format_number(input logic k, input logic [31:0] v);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [7:0]  digits[$];
        text_char_t  t;
        digits = {};
        mag = v;
        radix = (k == KIND_HEX) ? 32'd16 : 32'd10;
        if (k == KIND_DEC && v[31])
        begin
            mag = -v;
            t.ch = CHAR_MINUS;
            t.last = 1'b0;
            expected_text.push_back(t);
        end
        do
        begin
            digits.push_front(digit_to_ascii(mag % radix));
            mag = mag / radix;
        end while (mag != 0);
        foreach (digits[i])
        begin
            t.ch = digits[i];
            t.last = (i == digits.size() - 1);
            expected_text.push_back(t);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            errors = 0;
            expected_text.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                format_number(kind, value);
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected character %h", character);
                    errors++;
                end
                else
                begin
                    if (character !== expected_text[0].ch)
                    begin
                        $error("character: expected %h, actual %h",
                               expected_text[0].ch, character);
                        errors++;
                    end
                    if (last !== expected_text[0].last)
                    begin
                        $error("last: expected %b, actual %b", expected_text[0].last, last);
                        errors++;
                    end
                    void'(expected_text.pop_front());
                end
            end
        end
        pending = expected_text.size();
    end
endmodule

### sim/tb_top.sv
// Testbench top for the integer to ASCII formatter: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_top;
    import itoa_fmt_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  character;
    logic        last;
    int          errors;
    int          pending;
    int          cycles;
    bit          calm;
    int          long_hold;

    integer_to_ascii_formatter_top dut
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .value(value), .out_valid(out_valid), .out_ready(out_ready),
        .character(character), .last(last)
    );

    itoa_fmt_checker checker_i
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .value(value), .out_valid(out_valid), .out_ready(out_ready),
        .character(character), .last(last), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (long_hold) @(posedge clk);
                long_hold = 0;
            end
            else if (!calm && $urandom_range(3) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(8, 1);
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_number(input logic k, input logic [31:0] v);
        int n;
        if (!calm && $urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(8, 1);
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(5))
            0: return $urandom_range(9);
            1: return $urandom_range(65535);
            2: return -$urandom_range(100);
            3: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_DEC;
        value     = '0;
        calm      = 1'b0;
        long_hold = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed = '{32'h0, 32'h1, 32'h9, 32'ha, 32'hf, 32'h10, 32'h7fffffff,
                     32'h80000000, 32'hffffffff, 32'd999999999, 32'd1000000000,
                     32'hdeadbeef};
        foreach (directed[i])
        begin
            send_number(KIND_DEC, directed[i]);
            send_number(KIND_HEX, directed[i]);
        end
        // receiver holds off while the sender keeps offering
        long_hold = 300;
        for (int i = 0; i < 40; i++)
            send_number(1'($urandom_range(1)), random_word());
        // sender pauses until everything has drained
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 80)
                calm = 1'b1;
            send_number(1'($urandom_range(1)), random_word());
        end
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
